/* design/nearest_palette_color_search_core_defines.svh */
// assertion macros shared by the nearest palette color search modules
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef NEAREST_PALETTE_COLOR_SEARCH_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked outside reset
`define NPCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest palette search check failed");

// next-cycle implication, checked outside reset
`define NPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest palette search check failed");

`else

`define NPCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define NPCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/npcs_pkg.sv */
// shared types and constants for the nearest palette color search core
// no dependencies
package npcs_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int MAX_ENTRIES         = 256;

    localparam int CH_W   = 8;
    localparam int IDX_W  = 8;
    localparam int DIST_W = 14;

    // start bound beats nothing stored; largest real distance is 3 * 255
    localparam logic [DIST_W-1:0] START_BOUND = 14'd10000;
    localparam logic [DIST_W-1:0] MAX_DIST    = 14'd765;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic write;       // store the request color at entry_index
        logic load_query;  // latch query color, rewind scan
        logic read;        // read next palette entry
        logic load_out;    // move best index to the output register
    } t_cmd;

    typedef struct packed {
        logic last_addr;   // scan address sits on the final entry
        logic cmp_busy;    // a read entry is being compared this cycle
    } t_status;

endpackage

/* design/npcs_dpath.sv */
// datapath: palette memory with valid bits, distance unit, best tracker
// depends on npcs_pkg and the shared assertion macros
`include "nearest_palette_color_search_core_defines.svh"

module npcs_dpath #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  npcs_pkg::t_cmd              i_cmd,
    output npcs_pkg::t_status           o_status,
    input  logic [npcs_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [npcs_pkg::CH_W-1:0]   i_red,
    input  logic [npcs_pkg::CH_W-1:0]   i_green,
    input  logic [npcs_pkg::CH_W-1:0]   i_blue,
    output logic [npcs_pkg::IDX_W-1:0]  o_best_index
);
    import npcs_pkg::*;

    localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int ENT_W  = 3 * CH_W;

    logic [ENT_W-1:0]           r_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_valid;

    logic [CH_W-1:0]   r_qr, r_qg, r_qb;
    logic [ADDR_W-1:0] r_addr;
    logic [ENT_W-1:0]  r_rd_data;
    logic              r_rd_ok;
    logic [ADDR_W-1:0] r_rd_idx;
    logic              r_cmp_en;
    logic [DIST_W-1:0] r_best_dist;
    logic [ADDR_W-1:0] r_best_idx;
    logic [IDX_W-1:0]  r_out_idx;

    logic              w_in_range;
    logic [ENT_W-1:0]  w_ent;
    logic [CH_W-1:0]   w_dr, w_dg, w_db;
    logic [DIST_W-1:0] w_dist;
    logic              w_better;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign w_in_range = ({1'b0, i_entry_index} < (IDX_W+1)'(PALETTE_ENTRIES));

    // palette store; write only while idle, reads only during a scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && w_in_range) begin
            r_mem[i_entry_index[ADDR_W-1:0]] <= {i_red, i_green, i_blue};
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.write && w_in_range) begin
            r_valid[i_entry_index[ADDR_W-1:0]] <= 1'b1;
        end
    end

    assign w_ent = r_rd_ok ? r_rd_data : '0;
    assign w_dr  = abs_diff(r_qr, w_ent[ENT_W-1 -: CH_W]);
    assign w_dg  = abs_diff(r_qg, w_ent[2*CH_W-1 -: CH_W]);
    assign w_db  = abs_diff(r_qb, w_ent[CH_W-1:0]);
    assign w_dist = DIST_W'(w_dr) + DIST_W'(w_dg) + DIST_W'(w_db);
    assign w_better = (w_dist < r_best_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_en <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_qr        <= i_red;
            r_qg        <= i_green;
            r_qb        <= i_blue;
            r_addr      <= '0;
            r_best_dist <= START_BOUND;
            r_best_idx  <= '0;
        end else begin
            if (i_cmd.read) begin
                r_addr   <= r_addr + ADDR_W'(1);
                r_rd_idx <= r_addr;
                r_rd_ok  <= r_valid[r_addr];
            end
            // strict compare keeps the lowest index on a tie
            if (r_cmp_en && w_better) begin
                r_best_dist <= w_dist;
                r_best_idx  <= r_rd_idx;
            end
        end
        if (i_cmd.load_out) begin
            r_out_idx <= IDX_W'(r_best_idx);
        end
    end

    assign o_status.last_addr = (r_addr == ADDR_W'(PALETTE_ENTRIES - 1));
    assign o_status.cmp_busy  = r_cmp_en;
    assign o_best_index       = r_out_idx;

    `NPCS_ASSERT_IMPL(a_best_dist_bounded, i_clk, i_rst_n, $past(r_cmp_en) && !$past(i_cmd.load_query), r_best_dist <= MAX_DIST)
    `NPCS_ASSERT_NEXT(a_query_rewinds_scan, i_clk, i_rst_n, i_cmd.load_query, r_addr == '0 && r_best_dist == START_BOUND)
    `NPCS_ASSERT_IMPL(a_no_read_during_write, i_clk, i_rst_n, i_cmd.write, !i_cmd.read && !r_cmp_en)

endmodule

/* design/npcs_ctrl.sv */
// controller: request handshake, scan sequencing, result register control
// depends on npcs_pkg and the shared assertion macros
`include "nearest_palette_color_search_core_defines.svh"

module npcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output npcs_pkg::t_cmd    o_cmd,
    input  npcs_pkg::t_status i_status
);
    import npcs_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_func == FUNC_QUERY) begin
                        o_cmd.load_query = 1'b1;
                        n_state          = ST_SCAN;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.read = 1'b1;
                if (i_status.last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            // last entry is compared here
            ST_DRAIN: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `NPCS_ASSERT_NEXT(a_scan_ends_in_drain, i_clk, i_rst_n, r_state == ST_SCAN && i_status.last_addr, r_state == ST_DRAIN)
    `NPCS_ASSERT_IMPL(a_result_after_compare, i_clk, i_rst_n, r_state == ST_RESULT, !i_status.cmp_busy)
    `NPCS_ASSERT_IMPL(a_drain_follows_scan, i_clk, i_rst_n, r_state == ST_DRAIN, $past(r_state) == ST_SCAN)
    `NPCS_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.load_out, o_out_valid)

endmodule

/* design/nearest_palette_color_search_core.sv */
// top level of the nearest palette color search core
// depends on npcs_pkg, npcs_ctrl and npcs_dpath
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------------------------------
//  request  | in        | i_in_valid / o_in_ready    | i_func i_entry_index i_red ...
//  result   | out       | o_out_valid / i_out_ready  | o_best_index
//
// a palette write leaves the core idle and ready; a query scans every palette entry,
// limited by the single read port of the palette memory (one entry per cycle)
// a result waits in the output register; the next request is taken meanwhile,
// and a finished query stalls only when that register is still full
// reset marks every palette entry as zero at once, no clearing pass
module nearest_palette_color_search_core #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_func,
    input  logic [npcs_pkg::IDX_W-1:0] i_entry_index,
    input  logic [npcs_pkg::CH_W-1:0]  i_red,
    input  logic [npcs_pkg::CH_W-1:0]  i_green,
    input  logic [npcs_pkg::CH_W-1:0]  i_blue,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [npcs_pkg::IDX_W-1:0] o_best_index
);
    import npcs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    npcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    npcs_dpath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_entry_index (i_entry_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_best_index  (o_best_index)
    );

endmodule
